@@ rtl/sfdp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdp_pkg
// Shared types, command codes and field layout tables of the soft-font
// download parser.
// ----------------------------------------------------------------------------
package sfdp_pkg;

   localparam int NAME_BYTES_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int DESC_FIELD_BYTES = 48;
   localparam int HDR_BYTES        = 16;

   typedef enum logic [2:0] {
      KIND_DESC_START = 3'd0,
      KIND_DESC_FIELD = 3'd1,
      KIND_CHAR_CODE  = 3'd2,
      KIND_HDR_FIELD  = 3'd3,
      KIND_BITMAP     = 3'd4,
      KIND_ERROR      = 3'd5,
      KIND_NAME       = 3'd6
   } kind_type;

   // Class of one stream byte as seen by the command matcher
   typedef enum logic [3:0] {
      CC_ESC,
      CC_RPAREN,
      CC_LPAREN,
      CC_STAR,
      CC_LOWER_S,
      CC_LOWER_C,
      CC_UPPER_E,
      CC_UPPER_W,
      CC_DIGIT,
      CC_OTHER
   } char_class_type;

   // Expected command byte index; also the error code on a mismatch
   localparam logic [3:0] CMD_DESC_ESC = 4'd0;
   localparam logic [3:0] CMD_DESC_RP  = 4'd1;
   localparam logic [3:0] CMD_DESC_S   = 4'd2;
   localparam logic [3:0] CMD_DESC_W   = 4'd3;
   localparam logic [3:0] CMD_CODE_ESC = 4'd4;
   localparam logic [3:0] CMD_CODE_STR = 4'd5;
   localparam logic [3:0] CMD_CODE_C   = 4'd6;
   localparam logic [3:0] CMD_CODE_E   = 4'd7;
   localparam logic [3:0] CMD_DATA_ESC = 4'd8;
   localparam logic [3:0] CMD_DATA_LP  = 4'd9;
   localparam logic [3:0] CMD_DATA_S   = 4'd10;
   localparam logic [3:0] CMD_DATA_W   = 4'd11;

   localparam logic [4:0] HDR_FIELD_WIDTH  = 5'd8;
   localparam logic [4:0] HDR_FIELD_HEIGHT = 5'd9;

   typedef struct packed {
      logic [7:0]     data;
      char_class_type cls;
      logic [3:0]     digit;
   } byte_item_type;

   // Field index of each descriptor byte offset
   localparam logic [4:0] DESC_FIELD_OF [48] = '{
      5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd3,  5'd4,  5'd4,
      5'd5,  5'd5,  5'd6,  5'd6,  5'd7,  5'd8,  5'd9,  5'd9,
      5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd14,
      5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd19, 5'd20, 5'd21,
      5'd22, 5'd22, 5'd23, 5'd23, 5'd24, 5'd24, 5'd25, 5'd25,
      5'd26, 5'd27, 5'd28, 5'd28, 5'd29, 5'd29, 5'd30, 5'd30
   };

   // Field index of each character header byte offset
   localparam logic [4:0] HDR_FIELD_OF [16] = '{
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd6,
      5'd7, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9, 5'd10, 5'd10
   };

   // High byte of a two-byte descriptor field
   function automatic logic desc_first(input logic [5:0] pos);
      logic r;
      case (pos) inside
         6'd0, 6'd4, 6'd6, 6'd8, 6'd10, 6'd14, 6'd16, 6'd18, 6'd20,
         6'd28, 6'd32, 6'd34, 6'd36, 6'd38, 6'd42, 6'd44, 6'd46: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Low byte of a two-byte descriptor field
   function automatic logic desc_wide(input logic [5:0] pos);
      logic r;
      case (pos) inside
         6'd1, 6'd5, 6'd7, 6'd9, 6'd11, 6'd15, 6'd17, 6'd19, 6'd21,
         6'd29, 6'd33, 6'd35, 6'd37, 6'd39, 6'd43, 6'd45, 6'd47: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic hdr_first(input logic [3:0] pos);
      logic r;
      case (pos) inside
         4'd6, 4'd8, 4'd10, 4'd12, 4'd14: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic hdr_wide(input logic [3:0] pos);
      logic r;
      case (pos) inside
         4'd7, 4'd9, 4'd11, 4'd13, 4'd15: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic char_class_type expect_class(input logic [3:0] cmd);
      char_class_type r;
      unique case (cmd) inside
         CMD_DESC_ESC, CMD_CODE_ESC, CMD_DATA_ESC: r = CC_ESC;
         CMD_DESC_RP:                              r = CC_RPAREN;
         CMD_DATA_LP:                              r = CC_LPAREN;
         CMD_CODE_STR:                             r = CC_STAR;
         CMD_DESC_S, CMD_DATA_S:                   r = CC_LOWER_S;
         CMD_CODE_C:                               r = CC_LOWER_C;
         CMD_CODE_E:                               r = CC_UPPER_E;
         CMD_DESC_W, CMD_DATA_W:                   r = CC_UPPER_W;
         default:                                  r = CC_OTHER;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/sfdp_req_if.sv @@
// ----------------------------------------------------------------------------
// sfdp_req_if
// Byte stream channel into the parser: valid, ready and one raw byte.
// ----------------------------------------------------------------------------
interface sfdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;

   modport source (output valid, output byte_req, input ready);
   modport sink   (input valid, input byte_req, output ready);
endinterface

@@ rtl/sfdp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sfdp_rsp_if
// Result channel out of the parser: valid, ready and one decoded item.
// ----------------------------------------------------------------------------
interface sfdp_rsp_if;
   logic                 valid;
   logic                 ready;
   sfdp_pkg::kind_type   kind;
   logic [4:0]           field_index;
   logic [15:0]          value;
   logic [15:0]          row;
   logic [12:0]          column;
   logic                 last_of_glyph;
   logic [3:0]           error_code;

   modport source (output valid, output kind, output field_index, output value,
                   output row, output column, output last_of_glyph,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input field_index, input value,
                   input row, input column, input last_of_glyph,
                   input error_code, output ready);
endinterface

@@ rtl/sfdp_front.sv @@
// ----------------------------------------------------------------------------
// sfdp_front
// Accepts stream bytes and classifies each one (command byte, digit or
// other) before it enters the queue.
// ----------------------------------------------------------------------------
module sfdp_front (
   sfdp_req_if.sink               req_chan,
   output logic                   push_valid,
   output sfdp_pkg::byte_item_type push_item,
   input  logic                   push_ready
);

   sfdp_pkg::char_class_type cls;

   always_comb begin
      unique case (req_chan.byte_req) inside
         8'h1B:          cls = sfdp_pkg::CC_ESC;
         8'h29:          cls = sfdp_pkg::CC_RPAREN;
         8'h28:          cls = sfdp_pkg::CC_LPAREN;
         8'h2A:          cls = sfdp_pkg::CC_STAR;
         8'h73:          cls = sfdp_pkg::CC_LOWER_S;
         8'h63:          cls = sfdp_pkg::CC_LOWER_C;
         8'h45:          cls = sfdp_pkg::CC_UPPER_E;
         8'h57:          cls = sfdp_pkg::CC_UPPER_W;
         [8'h30:8'h39]:  cls = sfdp_pkg::CC_DIGIT;
         default:        cls = sfdp_pkg::CC_OTHER;
      endcase
   end

   assign push_item.data  = req_chan.byte_req;
   assign push_item.cls   = cls;
   assign push_item.digit = 4'(req_chan.byte_req - 8'h30);
   assign push_valid      = req_chan.valid;
   assign req_chan.ready  = push_ready;

endmodule

@@ rtl/sfdp_queue.sv @@
// ----------------------------------------------------------------------------
// sfdp_queue
// Small FIFO between the classifier and the parser; each side stalls
// independently.
// ----------------------------------------------------------------------------
module sfdp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/sfdp_back.sv @@
// ----------------------------------------------------------------------------
// sfdp_back
// Parser state machine: matches commands, assembles descriptor and header
// fields, walks the bitmap and registers one result item at a time.
// ----------------------------------------------------------------------------
module sfdp_back #(
   parameter int NAME_BYTES = sfdp_pkg::NAME_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  sfdp_pkg::byte_item_type item,
   output logic                    item_ready,
   sfdp_rsp_if.source              rsp_chan
);

   localparam int POS_W = $clog2((NAME_BYTES > sfdp_pkg::DESC_FIELD_BYTES) ?
                                 NAME_BYTES : sfdp_pkg::DESC_FIELD_BYTES);

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_NUMBER,
      PH_DFIELDS,
      PH_DNAME,
      PH_DSKIP,
      PH_GHDR,
      PH_GBITMAP
   } phase_type;

   typedef struct packed {
      sfdp_pkg::kind_type kind;
      logic [4:0]         field_index;
      logic [15:0]        value;
      logic [15:0]        row;
      logic [12:0]        column;
      logic               last_of_glyph;
      logic [3:0]         error_code;
   } result_type;

   phase_type        phase_ff, phase_in;
   logic             halted_ff, halted_in;
   logic [3:0]       cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      acc_ff, acc_in;
   logic [7:0]       hold_ff, hold_in;
   logic [15:0]      desc_count_ff, desc_count_in;
   logic [15:0]      desc_size_ff, desc_size_in;
   logic [15:0]      skip_ff, skip_in;
   logic [15:0]      width_ff, width_in;
   logic [15:0]      height_ff, height_in;
   logic [13:0]      cols_ff, cols_in;
   logic [15:0]      row_ff, row_in;
   logic [12:0]      col_ff, col_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       res_ff, res_in;

   logic             out_free, step, res_valid;
   logic [19:0]      acc_x10;
   logic [16:0]      width_p7;
   logic [5:0]       dpos;
   logic [3:0]       hpos;
   logic [15:0]      field_val;
   logic             last_col, last_row;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign item_ready = out_free;
   assign step       = item_valid && out_free;

   assign acc_x10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {16'h0, item.digit};
   assign width_p7 = {1'b0, field_val} + 17'd7;
   assign dpos     = pos_ff[5:0];
   assign hpos     = pos_ff[3:0];
   assign last_col = ({1'b0, col_ff} + 14'd1) >= cols_ff;
   assign last_row = ({1'b0, row_ff} + 17'd1) >= {1'b0, height_ff};

   always_comb begin
      field_val = {8'h00, item.data};
      if (phase_ff == PH_DFIELDS && sfdp_pkg::desc_wide(dpos)) begin
         field_val = {hold_ff, item.data};
      end else if (phase_ff == PH_GHDR && sfdp_pkg::hdr_wide(hpos)) begin
         field_val = {hold_ff, item.data};
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      halted_in     = halted_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      hold_in       = hold_ff;
      desc_count_in = desc_count_ff;
      desc_size_in  = desc_size_ff;
      skip_in       = skip_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      cols_in       = cols_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      res_valid     = 1'b0;
      res_in        = '0;

      if (step && !halted_ff) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (item.cls != sfdp_pkg::expect_class(cmd_ff)) begin
                  halted_in         = 1'b1;
                  res_valid         = 1'b1;
                  res_in.kind       = sfdp_pkg::KIND_ERROR;
                  res_in.error_code = cmd_ff;
               end else begin
                  cmd_in = cmd_ff + 4'd1;
                  // this byte was the command letter: a number follows, so start one
                  if (cmd_ff[1:0] == 2'd2) begin
                     phase_in = PH_NUMBER;
                     acc_in   = '0;
                  end
               end
            end
            PH_NUMBER: begin
               if (item.cls == sfdp_pkg::CC_DIGIT) begin
                  acc_in = (|acc_x10[19:16]) ? 16'hFFFF : acc_x10[15:0];
               end else if (item.cls != sfdp_pkg::expect_class(cmd_ff)) begin
                  halted_in         = 1'b1;
                  res_valid         = 1'b1;
                  res_in.kind       = sfdp_pkg::KIND_ERROR;
                  res_in.error_code = cmd_ff;
               end else if (cmd_ff == sfdp_pkg::CMD_DESC_W) begin
                  desc_count_in = acc_ff;
                  phase_in      = PH_DFIELDS;
                  pos_in        = '0;
                  res_valid     = 1'b1;
                  res_in.kind   = sfdp_pkg::KIND_DESC_START;
                  res_in.value  = acc_ff;
               end else if (cmd_ff == sfdp_pkg::CMD_CODE_E) begin
                  phase_in     = PH_PREFIX;
                  cmd_in       = sfdp_pkg::CMD_DATA_ESC;
                  res_valid    = 1'b1;
                  res_in.kind  = sfdp_pkg::KIND_CHAR_CODE;
                  res_in.value = acc_ff;
               end else begin
                  phase_in = PH_GHDR;
                  pos_in   = '0;
               end
            end
            PH_DFIELDS: begin
               if (sfdp_pkg::desc_first(dpos)) begin
                  hold_in = item.data;
               end else begin
                  res_valid          = 1'b1;
                  res_in.kind        = sfdp_pkg::KIND_DESC_FIELD;
                  res_in.field_index = sfdp_pkg::DESC_FIELD_OF[dpos];
                  res_in.value       = field_val;
                  if (sfdp_pkg::DESC_FIELD_OF[dpos] == 5'd0) begin
                     desc_size_in = field_val;
                  end
               end
               if (dpos == 6'(sfdp_pkg::DESC_FIELD_BYTES - 1)) begin
                  phase_in = PH_DNAME;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            PH_DNAME: begin
               res_valid          = 1'b1;
               res_in.kind        = sfdp_pkg::KIND_NAME;
               res_in.field_index = pos_ff[4:0];
               res_in.value       = {8'h00, item.data};
               if (pos_ff == POS_W'(NAME_BYTES - 1)) begin
                  if (desc_count_ff > desc_size_ff) begin
                     skip_in  = desc_count_ff - desc_size_ff;
                     phase_in = PH_DSKIP;
                  end else begin
                     skip_in  = '0;
                     phase_in = PH_PREFIX;
                     cmd_in   = sfdp_pkg::CMD_CODE_ESC;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            PH_DSKIP: begin
               // drop extra descriptor bytes
               if (skip_ff <= 16'd1) begin
                  skip_in  = '0;
                  phase_in = PH_PREFIX;
                  cmd_in   = sfdp_pkg::CMD_CODE_ESC;
               end else begin
                  skip_in = skip_ff - 16'd1;
               end
            end
            PH_GHDR: begin
               if (sfdp_pkg::hdr_first(hpos)) begin
                  hold_in = item.data;
               end else begin
                  res_valid          = 1'b1;
                  res_in.kind        = sfdp_pkg::KIND_HDR_FIELD;
                  res_in.field_index = sfdp_pkg::HDR_FIELD_OF[hpos];
                  res_in.value       = field_val;
                  if (sfdp_pkg::HDR_FIELD_OF[hpos] == sfdp_pkg::HDR_FIELD_WIDTH) begin
                     width_in = field_val;
                     cols_in  = width_p7[16:3];
                  end else if (sfdp_pkg::HDR_FIELD_OF[hpos] ==
                               sfdp_pkg::HDR_FIELD_HEIGHT) begin
                     height_in = field_val;
                  end
               end
               if (hpos == 4'(sfdp_pkg::HDR_BYTES - 1)) begin
                  row_in = '0;
                  col_in = '0;
                  pos_in = '0;
                  // an empty glyph has no bitmap
                  if (width_ff == '0 || height_ff == '0) begin
                     phase_in = PH_PREFIX;
                     cmd_in   = sfdp_pkg::CMD_CODE_ESC;
                  end else begin
                     phase_in = PH_GBITMAP;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            PH_GBITMAP: begin
               res_valid            = 1'b1;
               res_in.kind          = sfdp_pkg::KIND_BITMAP;
               res_in.value         = {8'h00, item.data};
               res_in.row           = row_ff;
               res_in.column        = col_ff;
               res_in.last_of_glyph = last_col && last_row;
               if (last_col && last_row) begin
                  phase_in = PH_PREFIX;
                  cmd_in   = sfdp_pkg::CMD_CODE_ESC;
                  row_in   = '0;
                  col_in   = '0;
               end else if (last_col) begin
                  col_in = '0;
                  row_in = row_ff + 16'd1;
               end else begin
                  col_in = col_ff + 13'd1;
               end
            end
            default: begin
               halted_in = 1'b1;
            end
         endcase
      end

      // advance the output register whenever its slot is free
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         halted_ff     <= 1'b0;
         cmd_ff        <= sfdp_pkg::CMD_DESC_ESC;
         pos_ff        <= '0;
         acc_ff        <= '0;
         hold_ff       <= '0;
         desc_count_ff <= '0;
         desc_size_ff  <= '0;
         skip_ff       <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         cols_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         halted_ff     <= halted_in;
         cmd_ff        <= cmd_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         hold_ff       <= hold_in;
         desc_count_ff <= desc_count_in;
         desc_size_ff  <= desc_size_in;
         skip_ff       <= skip_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         cols_ff       <= cols_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (step && res_valid) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = res_ff.kind;
   assign rsp_chan.field_index   = res_ff.field_index;
   assign rsp_chan.value         = res_ff.value;
   assign rsp_chan.row           = res_ff.row;
   assign rsp_chan.column        = res_ff.column;
   assign rsp_chan.last_of_glyph = res_ff.last_of_glyph;
   assign rsp_chan.error_code    = res_ff.error_code;

endmodule

@@ rtl/soft_font_download_parser_unit.sv @@
// ----------------------------------------------------------------------------
// soft_font_download_parser_unit
// Soft-font download stream parser: classifier, byte queue and parser back end.
// ----------------------------------------------------------------------------
// Path: a byte passes from the classifier into the queue, then the parser
// steps it and registers its result in the output register.
// Throughput: one byte per cycle while the output register is not stalled.
// Reset clears the queue and the output register and returns the parser to
// waiting for the descriptor escape, with the halt flag cleared.
// ----------------------------------------------------------------------------
module soft_font_download_parser_unit #(
   parameter int NAME_BYTES  = sfdp_pkg::NAME_BYTES_DEF,
   parameter int QUEUE_DEPTH = sfdp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sfdp_req_if.sink    req_chan,
   sfdp_rsp_if.source  rsp_chan
);

   localparam int ITEM_W = $bits(sfdp_pkg::byte_item_type);

   logic                    push_valid, push_ready;
   sfdp_pkg::byte_item_type push_item;
   logic                    pop_valid, pop_ready;
   logic [ITEM_W-1:0]       pop_bits;
   sfdp_pkg::byte_item_type pop_item;

   sfdp_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   sfdp_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_bits),
      .pop_ready  (pop_ready)
   );

   assign pop_item = sfdp_pkg::byte_item_type'(pop_bits);

   sfdp_back #(
      .NAME_BYTES (NAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule
